FILE: hdl/aesh_pkg.sv
// ----------------------------------------------------------------------------
// aesh_pkg
// Types, constants, tables and the AES round function for the lane hash.
// ----------------------------------------------------------------------------
package aesh_pkg;

    localparam int LANE_COUNT       = 16;
    localparam int BLOCK_SIZE_BYTES = 256;
    localparam int CFG_IDX_W        = 3;

    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_EN = 3'd4;

    typedef enum logic [3:0] {
        ST_ARM, ST_IDLE, ST_PRE, ST_ABSORB, ST_CROSS1, ST_CROSS2,
        ST_TAIL, ST_TREE, ST_ROT, ST_FINAL
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD, OP_ABSORB, OP_CROSS1, OP_CROSS2, OP_TREE, OP_ROT, OP_ARM, OP_FINAL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] step;
        logic [3:0] rd_addr;
        logic [1:0] level;
        logic       pad;
        logic       clear_row;
        logic       in_ready;
        logic       cfg_ready;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic cfg_valid;
        logic block_full;
        logic last_word;
        logic nonempty;
        logic len_zero;
        logic cfg_known;
        logic out_busy;
    } t_status;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SECRET [256] = '{
        8'h24,8'h3F,8'h6A,8'h88,8'h85,8'hA3,8'h08,8'hD3,8'h13,8'h19,8'h8A,8'h2E,8'h03,8'h70,8'h73,8'h44,
        8'hA4,8'h09,8'h38,8'h22,8'h29,8'h9F,8'h31,8'hD0,8'h08,8'h2E,8'hFA,8'h98,8'hEC,8'h4E,8'h6C,8'h89,
        8'h45,8'h28,8'h21,8'hE6,8'h38,8'hD0,8'h13,8'h77,8'hBE,8'h54,8'h66,8'hCF,8'h34,8'hE9,8'h0C,8'h6C,
        8'hC0,8'hAC,8'h29,8'hB7,8'hC9,8'h7C,8'h50,8'hDD,8'h3F,8'h84,8'hD5,8'hB5,8'hB5,8'h47,8'h09,8'h17,
        8'h92,8'h16,8'hD5,8'hD9,8'h89,8'h79,8'hFB,8'h1B,8'hD1,8'h31,8'h0B,8'hA6,8'h98,8'hDF,8'hB5,8'hAC,
        8'h2F,8'hFD,8'h72,8'hDB,8'hD0,8'h1A,8'hDF,8'hB7,8'hB8,8'hE1,8'hAF,8'hED,8'h6A,8'h26,8'h7E,8'h96,
        8'hBA,8'h7C,8'h90,8'h45,8'hF1,8'h2C,8'h7F,8'h99,8'h24,8'hA1,8'h99,8'h47,8'hB3,8'h91,8'h6C,8'hF7,
        8'h08,8'h01,8'hF2,8'hE2,8'h85,8'h8E,8'hFC,8'h16,8'h63,8'h69,8'h20,8'hD8,8'h71,8'h57,8'h4E,8'h69,
        8'hA4,8'h58,8'hFE,8'hA3,8'hF4,8'h93,8'h3D,8'h7E,8'h0D,8'h95,8'h74,8'h8F,8'h72,8'h8E,8'hB6,8'h58,
        8'h71,8'h8B,8'hCD,8'h58,8'h82,8'h15,8'h4A,8'hEE,8'h7B,8'h54,8'hA4,8'h1D,8'hC2,8'h5A,8'h59,8'hB5,
        8'h9C,8'h30,8'hD5,8'h39,8'h2A,8'hF2,8'h60,8'h13,8'hC5,8'hD1,8'hB0,8'h23,8'h28,8'h60,8'h85,8'hF0,
        8'hCA,8'h41,8'h79,8'h18,8'hB8,8'hDB,8'h38,8'hEF,8'h8E,8'h79,8'hDC,8'hB0,8'h60,8'h3A,8'h18,8'h0E,
        8'h6C,8'h9E,8'h0E,8'h8B,8'hB0,8'h1E,8'h8A,8'h3E,8'hD7,8'h15,8'h77,8'hC1,8'hBD,8'h31,8'h4B,8'h27,
        8'h78,8'hAF,8'h2F,8'hDA,8'h55,8'h60,8'h5C,8'h60,8'hE6,8'h55,8'h25,8'hF3,8'hAA,8'h55,8'hAB,8'h94,
        8'h57,8'h48,8'h98,8'h62,8'h63,8'hE8,8'h14,8'h40,8'h55,8'hCA,8'h39,8'h6A,8'h2A,8'hAB,8'h10,8'hB6,
        8'hB4,8'hCC,8'h5C,8'h34,8'h11,8'h41,8'hE8,8'hCE,8'hA1,8'h54,8'h86,8'hAF,8'h7C,8'h72,8'hE9,8'h93
    };

    function automatic logic [127:0] secret_row(input logic [3:0] idx);
        logic [127:0] row;
        row = '0;
        for (int j = 0; j < 16; j++) begin
            row[8*j +: 8] = SECRET[{idx, 4'(j)}];
        end
        return row;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // SubBytes, ShiftRows, MixColumns, then key XOR
    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] key);
        logic [7:0]   sh [16];
        logic [127:0] res;
        logic [7:0]   a0, a1, a2, a3;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sh[r + 4*c] = SBOX[st[8*(r + 4*((c + r) & 3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sh[4*c];
            a1 = sh[4*c + 1];
            a2 = sh[4*c + 2];
            a3 = sh[4*c + 3];
            res[8*(4*c)     +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3 ^ key[8*(4*c) +: 8];
            res[8*(4*c + 1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ key[8*(4*c + 1) +: 8];
            res[8*(4*c + 2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3 ^ key[8*(4*c + 2) +: 8];
            res[8*(4*c + 3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3) ^ key[8*(4*c + 3) +: 8];
        end
        return res;
    endfunction

endpackage

FILE: hdl/aesh_if.sv
// ----------------------------------------------------------------------------
// aesh_if
// Valid/ready channel interfaces: message words, digests, register writes.
// ----------------------------------------------------------------------------
interface aesh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface aesh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;
    modport source (output valid, digest_low, digest_high, input ready);
    modport sink   (input valid, digest_low, digest_high, output ready);
endinterface

interface aesh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [aesh_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/aesh_ctrl.sv
// ----------------------------------------------------------------------------
// aesh_ctrl
// Sequencer: request intake, block absorb, lane cross, reduction tree, re-arm.
// ----------------------------------------------------------------------------
module aesh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aesh_pkg::t_status i_status,
    output aesh_pkg::t_cmd    o_cmd
);

    aesh_pkg::t_state r_state, n_state;
    logic [3:0]       r_cnt, n_cnt;
    logic [1:0]       r_level, n_level;
    logic             r_pad, n_pad;
    logic             r_last, n_last;
    logic             r_fin, n_fin;
    logic [3:0]       tree_steps;

    assign tree_steps = 4'd8 >> r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aesh_pkg::ST_ARM;
            r_cnt   <= '0;
            r_level <= '0;
            r_pad   <= 1'b0;
            r_last  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_level <= n_level;
            r_pad   <= n_pad;
            r_last  <= n_last;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 4'd1;
        n_level = r_level;
        n_pad   = r_pad;
        n_last  = r_last;
        n_fin   = r_fin;
        o_cmd           = '0;
        o_cmd.op        = aesh_pkg::OP_HOLD;
        o_cmd.step      = r_cnt;
        o_cmd.rd_addr   = r_cnt + 4'd1;
        o_cmd.level     = r_level;
        o_cmd.pad       = r_pad;
        unique case (r_state)
            aesh_pkg::ST_ARM: begin
                o_cmd.op = aesh_pkg::OP_ARM;
                if (r_cnt == 4'd15) begin
                    n_state = aesh_pkg::ST_IDLE;
                end
            end
            aesh_pkg::ST_IDLE: begin
                n_cnt           = '0;
                o_cmd.in_ready  = 1'b1;
                o_cmd.cfg_ready = !i_status.in_valid;
                if (i_status.in_valid) begin
                    n_last = i_status.last_word;
                    if (i_status.block_full) begin
                        n_pad   = 1'b0;
                        n_state = aesh_pkg::ST_PRE;
                    end else if (i_status.last_word) begin
                        n_state = aesh_pkg::ST_TAIL;
                    end
                end else if (i_status.cfg_valid && i_status.cfg_known && i_status.len_zero) begin
                    n_state = aesh_pkg::ST_ARM;
                end
            end
            aesh_pkg::ST_PRE: begin
                o_cmd.rd_addr = '0;
                n_cnt         = '0;
                n_state       = aesh_pkg::ST_ABSORB;
            end
            aesh_pkg::ST_ABSORB: begin
                o_cmd.op = aesh_pkg::OP_ABSORB;
                if (r_cnt == 4'd15) begin
                    o_cmd.clear_row = r_pad;
                    n_state         = aesh_pkg::ST_CROSS1;
                end
            end
            aesh_pkg::ST_CROSS1: begin
                o_cmd.op = aesh_pkg::OP_CROSS1;
                if (r_cnt == 4'd7) begin
                    n_cnt   = '0;
                    n_state = aesh_pkg::ST_CROSS2;
                end
            end
            aesh_pkg::ST_CROSS2: begin
                o_cmd.op = aesh_pkg::OP_CROSS2;
                if (r_cnt == 4'd7) begin
                    n_cnt = '0;
                    if (r_fin) begin
                        n_level = '0;
                        n_state = aesh_pkg::ST_TREE;
                    end else if (r_last) begin
                        n_state = aesh_pkg::ST_TAIL;
                    end else begin
                        n_state = aesh_pkg::ST_IDLE;
                    end
                end
            end
            aesh_pkg::ST_TAIL: begin
                n_cnt = '0;
                if (i_status.nonempty) begin
                    n_pad   = 1'b1;
                    n_state = aesh_pkg::ST_PRE;
                end else begin
                    n_fin   = 1'b1;
                    n_state = aesh_pkg::ST_CROSS1;
                end
            end
            aesh_pkg::ST_TREE: begin
                o_cmd.op = aesh_pkg::OP_TREE;
                if (r_cnt == tree_steps - 4'd1) begin
                    n_cnt   = '0;
                    n_state = aesh_pkg::ST_ROT;
                end
            end
            aesh_pkg::ST_ROT: begin
                o_cmd.op = aesh_pkg::OP_ROT;
                if (r_cnt == 4'd15 - tree_steps) begin
                    n_cnt = '0;
                    if (r_level == 2'd3) begin
                        n_state = aesh_pkg::ST_FINAL;
                    end else begin
                        n_level = r_level + 2'd1;
                        n_state = aesh_pkg::ST_TREE;
                    end
                end
            end
            aesh_pkg::ST_FINAL: begin
                n_cnt = '0;
                if (!i_status.out_busy) begin
                    o_cmd.op = aesh_pkg::OP_FINAL;
                    n_last   = 1'b0;
                    n_fin    = 1'b0;
                    n_pad    = 1'b0;
                    n_state  = aesh_pkg::ST_ARM;
                end
            end
            default: begin
                n_state = aesh_pkg::ST_IDLE;
            end
        endcase
    end

    a_no_dual_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.in_ready && i_status.in_valid && o_cmd.cfg_ready && i_status.cfg_valid))
        else $error("request and register write taken together");

    a_absorb_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == aesh_pkg::ST_ABSORB) |-> $past(r_state) == aesh_pkg::ST_PRE)
        else $error("absorb entered without read prefetch");

    a_final_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == aesh_pkg::OP_FINAL) |-> !i_status.out_busy)
        else $error("digest overwritten while pending");

    a_reset_arm: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == aesh_pkg::ST_ARM)
        else $error("reset does not re-arm lanes");

endmodule

FILE: hdl/aesh_dp.sv
// ----------------------------------------------------------------------------
// aesh_dp
// Lane ring, block buffer, byte packer, config registers and the round unit.
// ----------------------------------------------------------------------------
module aesh_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aesh_pkg::t_cmd    i_cmd,
    output aesh_pkg::t_status o_status,
    aesh_in_if.sink           i_in,
    aesh_cfg_if.sink          i_cfg,
    aesh_out_if.source        o_out
);

    logic [127:0] r_lane [aesh_pkg::LANE_COUNT];
    logic [127:0] r_t    [aesh_pkg::LANE_COUNT/2];
    logic [127:0] r_mem  [aesh_pkg::LANE_COUNT];
    logic [127:0] r_rd;
    logic [127:0] r_row;
    logic [3:0]   r_row_fill;
    logic [3:0]   r_row_idx;
    logic [63:0]  r_len;
    logic [63:0]  r_seed0, r_seed1, r_seed2, r_seed3;
    logic         r_seed_en;
    logic [63:0]  r_k;
    logic [63:0]  r_dig_lo, r_dig_hi;
    logic         r_out_valid;

    logic         take_in, take_cfg, shift;
    logic [3:0]   nbytes;
    logic [63:0]  word_m;
    logic [127:0] row_m;
    logic [191:0] packed_w;
    logic [4:0]   total;
    logic [127:0] blk, merged, rnd_st, rnd_key, rnd, tail, tap, sec_c;
    logic [63:0]  k_cur;

    assign take_in  = i_cmd.in_ready && i_in.valid;
    assign take_cfg = i_cmd.cfg_ready && i_cfg.valid;
    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = i_cmd.cfg_ready;

    assign nbytes = (i_in.valid_bytes > 4'd8) ? 4'd8 : i_in.valid_bytes;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            word_m[8*b +: 8] = (4'(b) < nbytes) ? i_in.data_word[8*b +: 8] : 8'h00;
        end
        for (int b = 0; b < 16; b++) begin
            row_m[8*b +: 8] = (4'(b) < r_row_fill) ? r_row[8*b +: 8] : 8'h00;
            merged[8*b +: 8] = (4'(b) < r_row_fill) ? r_row[8*b +: 8] : sec_c[8*b +: 8];
        end
    end

    assign packed_w = ({128'd0, word_m} << {r_row_fill, 3'b000}) | {64'd0, row_m};
    assign total    = {1'b0, r_row_fill} + {1'b0, nbytes};

    assign sec_c = aesh_pkg::secret_row(i_cmd.step);
    assign k_cur = (i_cmd.step == 4'd0) ? 64'd0 : r_k;

    always_comb begin
        if (!i_cmd.pad || i_cmd.step < r_row_idx) begin
            blk = r_rd;
        end else if (i_cmd.step == r_row_idx) begin
            blk = merged;
        end else begin
            blk = sec_c;
        end
    end

    always_comb begin
        case (i_cmd.level)
            2'd0:    tap = r_lane[8];
            2'd1:    tap = r_lane[4];
            2'd2:    tap = r_lane[2];
            default: tap = r_lane[1];
        endcase
    end

    always_comb begin
        rnd_st  = r_lane[0];
        rnd_key = tap;
        case (i_cmd.op)
            aesh_pkg::OP_ABSORB: rnd_key = blk ^ aesh_pkg::secret_row(4'd15 - i_cmd.step);
            aesh_pkg::OP_CROSS1: rnd_key = r_lane[8];
            aesh_pkg::OP_CROSS2: rnd_key = r_t[0];
            aesh_pkg::OP_ARM: begin
                rnd_st  = sec_c ^ {r_seed1, r_seed0} ^ {k_cur, ~k_cur};
                rnd_key = {r_seed3, r_seed2};
            end
            aesh_pkg::OP_FINAL:  rnd_key = {r_len, ~r_len};
            default:             rnd_key = tap;
        endcase
    end

    assign rnd = aesh_pkg::aes_round(rnd_st, rnd_key);

    always_comb begin
        tail  = rnd;
        shift = 1'b1;
        case (i_cmd.op)
            aesh_pkg::OP_ROT:   tail = r_lane[0];
            aesh_pkg::OP_ARM:   tail = r_seed_en ? rnd : sec_c;
            aesh_pkg::OP_HOLD,
            aesh_pkg::OP_FINAL: shift = 1'b0;
            default:            tail = rnd;
        endcase
    end

    // lane ring, cross temp, buffer memory and read, packer row, arm key and digest
    always_ff @(posedge i_clk) begin
        if (shift) begin
            for (int i = 0; i < aesh_pkg::LANE_COUNT - 1; i++) begin
                r_lane[i] <= r_lane[i+1];
            end
            r_lane[aesh_pkg::LANE_COUNT-1] <= tail;
        end
        if (i_cmd.op == aesh_pkg::OP_CROSS1 || i_cmd.op == aesh_pkg::OP_CROSS2) begin
            for (int i = 0; i < aesh_pkg::LANE_COUNT/2 - 1; i++) begin
                r_t[i] <= r_t[i+1];
            end
            r_t[aesh_pkg::LANE_COUNT/2-1] <= r_lane[0];
        end
        if (i_cmd.op == aesh_pkg::OP_ARM) begin
            r_k <= k_cur + aesh_pkg::GOLDEN_STEP;
        end
        if (take_in && total[4]) begin
            r_mem[r_row_idx] <= packed_w[127:0];
        end
        r_rd <= r_mem[i_cmd.rd_addr];
        if (take_in) begin
            r_row <= total[4] ? packed_w[191:64+64] : packed_w[127:0];
        end
        if (i_cmd.op == aesh_pkg::OP_FINAL) begin
            r_dig_lo <= rnd[63:0];
            r_dig_hi <= rnd[127:64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_fill  <= '0;
            r_row_idx   <= '0;
            r_len       <= '0;
            r_seed0     <= '0;
            r_seed1     <= '0;
            r_seed2     <= '0;
            r_seed3     <= '0;
            r_seed_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_len      <= r_len + 64'(nbytes);
                r_row_fill <= total[3:0];
                if (total[4]) begin
                    r_row_idx <= r_row_idx + 4'd1;
                end
            end else if (i_cmd.clear_row) begin
                r_row_fill <= '0;
                r_row_idx  <= '0;
            end
            if (i_cmd.op == aesh_pkg::OP_FINAL) begin
                r_len       <= '0;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (take_cfg) begin
                unique case (i_cfg.index)
                    aesh_pkg::CFG_SEED0:   r_seed0   <= i_cfg.data;
                    aesh_pkg::CFG_SEED1:   r_seed1   <= i_cfg.data;
                    aesh_pkg::CFG_SEED2:   r_seed2   <= i_cfg.data;
                    aesh_pkg::CFG_SEED3:   r_seed3   <= i_cfg.data;
                    aesh_pkg::CFG_SEED_EN: r_seed_en <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_low  = r_dig_lo;
    assign o_out.digest_high = r_dig_hi;

    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_in.valid;
        o_status.cfg_valid  = i_cfg.valid;
        o_status.block_full = total[4] && (r_row_idx == 4'd15);
        o_status.last_word  = i_in.last_word;
        o_status.nonempty   = (r_row_idx != 4'd0) || (r_row_fill != 4'd0);
        o_status.len_zero   = (r_len == 64'd0);
        o_status.cfg_known  = (i_cfg.index == aesh_pkg::CFG_SEED0) ||
                              (i_cfg.index == aesh_pkg::CFG_SEED1) ||
                              (i_cfg.index == aesh_pkg::CFG_SEED2) ||
                              (i_cfg.index == aesh_pkg::CFG_SEED3) ||
                              (i_cfg.index == aesh_pkg::CFG_SEED_EN);
        o_status.out_busy   = r_out_valid;
    end

endmodule

FILE: hdl/aes_round_lane_hash.sv
// ----------------------------------------------------------------------------
// aes_round_lane_hash
// 128-bit AES-round lane hash over a stream of 64-bit message words.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while idle; each full 256-byte block stalls input
//   for a read prefetch, 16 absorb rounds and 16 cross rounds on the single round unit.
// After a last word: up to two block absorbs, 16 cross rounds, a reduction
//   tree with lane rotation, then a final round once the output is free.
// The lanes are re-armed after each digest, after reset, and after a write
//   to a known register with no message in progress; no request is taken meanwhile.
module aes_round_lane_hash (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aesh_in_if.sink    i_in,
    aesh_cfg_if.sink   i_cfg,
    aesh_out_if.source o_out
);

    aesh_pkg::t_cmd    cmd;
    aesh_pkg::t_status status;

    aesh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    aesh_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .o_out    (o_out)
    );

endmodule
